[sv/bia_pkg.sv]
// ============================================================================
// bia_pkg - shared types and codes for the indexed block allocator
// Field widths of the request, response and register words, command and
// status codes, and the encoding of one allocation map word.
// ============================================================================
package bia_pkg;

   // word field widths
   localparam int CMD_W      = 2;
   localparam int BLOCK_W    = 10;
   localparam int LEN_IN_W   = 7;
   localparam int CFG_W      = 11;
   localparam int STATUS_W   = 3;
   localparam int FREE_OUT_W = 11;

   // request commands; code three means nothing and is dropped
   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_ENTRY = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_FULL        = 3'd1,
      STATUS_INDEX_TAKEN = 3'd2,
      STATUS_NOT_ENOUGH  = 3'd3,
      STATUS_SELF_INDEX  = 3'd4,
      STATUS_TAKEN       = 3'd5,
      STATUS_RANGE       = 3'd6
   } status_type;

   // map word: bit 0 allocated, bit 1 marked by the list check in progress
   localparam int MAP_W             = 2;
   localparam int MAP_ALLOC_BIT     = 0;
   localparam int MAP_MARK_BIT      = 1;
   localparam logic [MAP_W-1:0] MAP_CLEAR  = 2'b00;
   localparam logic [MAP_W-1:0] MAP_TAKEN  = 2'b01;
   localparam logic [MAP_W-1:0] MAP_MARKED = 2'b10;

endpackage

[sv/bia_ram.sv]
// ============================================================================
// bia_ram - generic simple dual-port RAM
// One write port and one read port, read data registered, no reset.
// ============================================================================
module bia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/indexed_block_allocator.sv]
// ============================================================================
// indexed_block_allocator - indexed file allocation over a block bitmap
// Keeps an allocation map and a free count, takes an index block with a list
// of data blocks, checks the list as a whole and commits it, answers queries.
// ============================================================================
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  --------------------------
//  request  req_command, req_block_number,          start & !busy
//           req_list_length
//  response rsp_status, rsp_is_allocated,           rsp_valid, one cycle,
//           rsp_free_blocks                         always taken
//  register csr_wdata (blocks_in_use)               csr_valid & csr_ready
//
//  Start and query read the map before their response strobe, unless the word
//  alone is rejected; a list entry that is not the last is only stored, and a
//  last entry rejected for self index or range responds without a map walk.
//  Otherwise the last entry runs the list check through the map RAM port: a
//  first walk checks and marks the entries, a second walk commits or unmarks
//  the entries marked, and a commit marks the index block before responding.
//  After reset and after each register write the map is cleared, one word a
//  cycle, all MAP_DEPTH words (at most 1024) with busy high. The response side
//  cannot stall; register writes are always taken.
// ============================================================================
module indexed_block_allocator #(
   parameter int MAX_BLOCKS = 1024,
   parameter int MAX_LIST   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            start,
   output logic                            busy,
   input  logic [bia_pkg::CMD_W-1:0]       req_command,
   input  logic [bia_pkg::BLOCK_W-1:0]     req_block_number,
   input  logic [bia_pkg::LEN_IN_W-1:0]    req_list_length,
   // response
   output logic                            rsp_valid,
   output logic [bia_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_is_allocated,
   output logic [bia_pkg::FREE_OUT_W-1:0]  rsp_free_blocks,
   // register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bia_pkg::CFG_W-1:0]       csr_wdata
);

   import bia_pkg::*;

   // block numbers are 10 bits wide, so at most 1024 map words are reachable
   localparam int MAP_DEPTH = (MAX_BLOCKS < (1 << BLOCK_W)) ? MAX_BLOCKS : (1 << BLOCK_W);
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int BUF_AW    = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
   localparam int LEN_W     = $clog2(MAX_LIST + 1);
   localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
   localparam int CW        = (CNT_W > 12) ? CNT_W : 12;

   localparam logic [MAP_AW-1:0] MAP_LAST      = MAP_AW'(MAP_DEPTH - 1);
   localparam logic [CW-1:0]     MAX_BLOCKS_CW = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0]     MAX_LIST_CW   = CW'(MAX_LIST);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START_CHK,
      S_QUERY_RD,
      S_W1_ADDR,
      S_W1_BUF,
      S_W1_MAP,
      S_W2_ADDR,
      S_W2_BUF,
      S_IDX_WR
   } state_type;

   // registers
   state_type              state_ff,    state_in;
   logic [MAP_AW-1:0]      clr_ff,      clr_in;
   logic [CNT_W-1:0]       biu_ff,      biu_in;
   logic [CNT_W-1:0]       free_ff,     free_in;
   logic                   collect_ff,  collect_in;
   logic [BLOCK_W-1:0]     pend_ff,     pend_in;
   logic [LEN_W-1:0]       len_ff,      len_in;
   logic [LEN_W-1:0]       left_ff,     left_in;
   logic [LEN_W-1:0]       total_ff,    total_in;
   logic [LEN_W-1:0]       idx_ff,      idx_in;
   logic [LEN_W-1:0]       stop_ff,     stop_in;
   logic                   pass_ff,     pass_in;
   logic                   self_ff,     self_in;
   logic                   range_ff,    range_in;
   logic [BLOCK_W-1:0]     ent_ff,      ent_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_alloc_ff, rsp_alloc_in;
   logic [FREE_OUT_W-1:0]  rsp_free_ff, rsp_free_in;

   // RAM ports
   logic                   map_we;
   logic [MAP_AW-1:0]      map_wa;
   logic [MAP_W-1:0]       map_wd;
   logic [MAP_AW-1:0]      map_ra;
   logic [MAP_W-1:0]       map_rd;
   logic                   buf_we;
   logic [BUF_AW-1:0]      buf_wa;
   logic [BLOCK_W-1:0]     buf_wd;
   logic [BUF_AW-1:0]      buf_ra;
   logic [BLOCK_W-1:0]     buf_rd;

   // helpers
   logic                   accept;
   logic                   blk_in_range;
   logic [LEN_W-1:0]       idx_inc;
   logic [CW-1:0]          free_wide;
   logic [CW-1:0]          cfg_wide;

   bia_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_addr (map_ra),
      .rd_data (map_rd)
   );

   bia_ram #(.WIDTH(BLOCK_W), .DEPTH(MAX_LIST)) u_list (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_wa),
      .wr_data (buf_wd),
      .rd_addr (buf_ra),
      .rd_data (buf_rd)
   );

   assign accept       = start && (state_ff == S_IDLE);
   assign blk_in_range = CW'(req_block_number) < CW'(biu_ff);
   assign idx_inc      = idx_ff + LEN_W'(1);
   assign cfg_wide     = CW'(csr_wdata);

   // sequencer: next state, RAM port control, response word
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      biu_in        = biu_ff;
      free_in       = free_ff;
      collect_in    = collect_ff;
      pend_in       = pend_ff;
      len_in        = len_ff;
      left_in       = left_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      stop_in       = stop_ff;
      pass_in       = pass_ff;
      self_in       = self_ff;
      range_in      = range_ff;
      ent_in        = ent_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_alloc_in  = 1'b0;
      rsp_free_in   = rsp_free_ff;

      map_we = 1'b0;
      map_wa = pend_ff[MAP_AW-1:0];
      map_wd = MAP_CLEAR;
      map_ra = req_block_number[MAP_AW-1:0];
      buf_we = 1'b0;
      buf_wa = total_ff[BUF_AW-1:0];
      buf_wd = req_block_number;
      buf_ra = idx_ff[BUF_AW-1:0];

      unique case (state_ff)
         // clear one map word a cycle
         S_CLEAR: begin
            map_we = 1'b1;
            map_wa = clr_ff;
            map_wd = MAP_CLEAR;
            clr_in = clr_ff + MAP_AW'(1);
            if (clr_ff == MAP_LAST) begin
               state_in = S_IDLE;
            end
         end

         // take a request word
         S_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_command))
                  CMD_START: begin
                     collect_in = 1'b0;
                     left_in    = '0;
                     total_in   = '0;
                     if (free_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else if (!blk_in_range ||
                                  CW'(req_list_length) > MAX_LIST_CW) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        // index block word comes back next cycle
                        pend_in  = req_block_number;
                        len_in   = LEN_W'(req_list_length);
                        state_in = S_START_CHK;
                     end
                  end
                  CMD_ENTRY: begin
                     if (!collect_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        buf_we   = 1'b1;
                        total_in = total_ff + LEN_W'(1);
                        left_in  = left_ff - LEN_W'(1);
                        self_in  = self_ff || (req_block_number == pend_ff);
                        range_in = range_ff || !blk_in_range;
                        if (left_ff == LEN_W'(1)) begin
                           collect_in = 1'b0;
                           if (self_in) begin
                              rsp_valid_in  = 1'b1;
                              rsp_status_in = STATUS_SELF_INDEX;
                              total_in      = '0;
                           end else if (range_in) begin
                              rsp_valid_in  = 1'b1;
                              rsp_status_in = STATUS_RANGE;
                              total_in      = '0;
                           end else begin
                              idx_in   = '0;
                              state_in = S_W1_ADDR;
                           end
                        end
                     end
                  end
                  CMD_QUERY: begin
                     if (!blk_in_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        state_in = S_QUERY_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // index block word is in; finish the start checks
         S_START_CHK: begin
            state_in = S_IDLE;
            if (map_rd[MAP_ALLOC_BIT]) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_INDEX_TAKEN;
            end else if (CW'(free_ff) < CW'(len_ff) + CW'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_ENOUGH;
            end else if (len_ff == '0) begin
               map_we        = 1'b1;
               map_wd        = MAP_TAKEN;
               free_in       = free_ff - CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
            end else begin
               collect_in = 1'b1;
               left_in    = len_ff;
               total_in   = '0;
               self_in    = 1'b0;
               range_in   = 1'b0;
            end
         end

         S_QUERY_RD: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_alloc_in  = map_rd[MAP_ALLOC_BIT];
         end

         // first walk: every entry must be free and not yet marked
         S_W1_ADDR: begin
            state_in = S_W1_BUF;
         end

         S_W1_BUF: begin
            map_ra   = buf_rd[MAP_AW-1:0];
            ent_in   = buf_rd;
            state_in = S_W1_MAP;
         end

         S_W1_MAP: begin
            buf_ra = idx_inc[BUF_AW-1:0];
            if (map_rd != MAP_CLEAR) begin
               // taken or repeated: unmark what was marked so far
               pass_in = 1'b0;
               stop_in = idx_ff;
               idx_in  = '0;
               if (idx_ff == '0) begin
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_TAKEN;
                  total_in      = '0;
               end else begin
                  state_in = S_W2_ADDR;
               end
            end else begin
               map_we = 1'b1;
               map_wa = ent_ff[MAP_AW-1:0];
               map_wd = MAP_MARKED;
               idx_in = idx_inc;
               if (idx_inc == total_ff) begin
                  pass_in  = 1'b1;
                  stop_in  = total_ff;
                  idx_in   = '0;
                  state_in = S_W2_ADDR;
               end else begin
                  state_in = S_W1_BUF;
               end
            end
         end

         // second walk: commit or unmark the marked entries
         S_W2_ADDR: begin
            state_in = S_W2_BUF;
         end

         S_W2_BUF: begin
            buf_ra = idx_inc[BUF_AW-1:0];
            map_we = 1'b1;
            map_wa = buf_rd[MAP_AW-1:0];
            map_wd = pass_ff ? MAP_TAKEN : MAP_CLEAR;
            idx_in = idx_inc;
            if (idx_inc == stop_ff) begin
               if (pass_ff) begin
                  state_in = S_IDX_WR;
               end else begin
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_TAKEN;
                  total_in      = '0;
               end
            end
         end

         // mark the index block and charge the free count
         S_IDX_WR: begin
            map_we        = 1'b1;
            map_wd        = MAP_TAKEN;
            free_in       = CNT_W'(CW'(free_ff) - CW'(total_ff) - CW'(1));
            total_in      = '0;
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // free count as reported with the response word
      free_wide = CW'(free_in);
      if (rsp_valid_in) begin
         rsp_free_in = free_wide[FREE_OUT_W-1:0];
      end

      // register write: clamp, reload the count, restart the clear sweep
      if (csr_valid) begin
         if (cfg_wide == '0) begin
            biu_in = CNT_W'(1);
         end else if (cfg_wide > MAX_BLOCKS_CW) begin
            biu_in = CNT_W'(MAX_BLOCKS);
         end else begin
            biu_in = CNT_W'(cfg_wide);
         end
         free_in    = biu_in;
         collect_in = 1'b0;
         left_in    = '0;
         total_in   = '0;
         pend_in    = '0;
         clr_in     = '0;
         state_in   = S_CLEAR;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         biu_ff       <= CNT_W'(MAX_BLOCKS);
         free_ff      <= CNT_W'(MAX_BLOCKS);
         collect_ff   <= 1'b0;
         pend_ff      <= '0;
         left_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         biu_ff       <= biu_in;
         free_ff      <= free_in;
         collect_ff   <= collect_in;
         pend_ff      <= pend_in;
         left_ff      <= left_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      stop_ff       <= stop_in;
      pass_ff       <= pass_in;
      self_ff       <= self_in;
      range_ff      <= range_in;
      ent_ff        <= ent_in;
      rsp_status_ff <= rsp_status_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_is_allocated = rsp_alloc_ff;
   assign rsp_free_blocks  = rsp_free_ff;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top - self-checking bench for the indexed block allocator
// A queue-fed driver issues start, entry, query and dropped commands with
// random gaps, a monitor predicts every reply from its own copy of the map
// and free count and checks each reply field by field as it arrives. The
// block count register is rewritten between phases, extremes included.
// ============================================================================
module tb_top;
   import bia_pkg::*;

   localparam int BLOCKS_MAX    = 1024;
   localparam int LIST_MAX      = 64;
   localparam int SETTLE_CYCLES = 300;
   localparam int QUIET_LIMIT   = 8000;

   // code three carries no command and is dropped by the block
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   // kinds of damage done to one random list; larger draws leave it clean
   localparam int FAULT_SELF   = 0;
   localparam int FAULT_REPEAT = 1;
   localparam int FAULT_RANGE  = 2;
   localparam int FAULT_SHORT  = 3;
   localparam int FAULT_QUERY  = 4;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [BLOCK_W-1:0]  blk;
      logic [LEN_IN_W-1:0] len;
      int                  gap;
      bit                  drain;
   } req_word_type;

   typedef struct {
      status_type            status;
      logic                  is_allocated;
      logic [FREE_OUT_W-1:0] free_blocks;
   } reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CMD_W-1:0]      req_command = '0;
   logic [BLOCK_W-1:0]    req_block_number = '0;
   logic [LEN_IN_W-1:0]   req_list_length = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_is_allocated;
   logic [FREE_OUT_W-1:0] rsp_free_blocks;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_wdata = '0;

   // stimulus and expectation stores
   req_word_type pending_words[$];
   reply_type    expected_replies[$];

   // shadow copy of the allocator state
   bit                    shadow_map [0:BLOCKS_MAX-1];
   logic [FREE_OUT_W-1:0] shadow_free = 11'(BLOCKS_MAX);
   int                    shadow_limit = BLOCKS_MAX;
   logic [BLOCK_W-1:0]    entry_buf [0:LIST_MAX-1];
   logic [BLOCK_W-1:0]    pending_index = '0;
   int                    entries_left = 0;
   int                    list_fill = 0;
   bit                    collecting = 1'b0;

   // bookkeeping
   bit drain_hold = 1'b0;
   bit no_idle    = 1'b0;
   int gap_left   = 0;
   int mismatch_count = 0;
   int words_sent = 0;
   int words_accepted = 0;
   int replies_checked = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;

   indexed_block_allocator #(
      .MAX_BLOCKS(BLOCKS_MAX),
      .MAX_LIST  (LIST_MAX)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_block_number(req_block_number),
      .req_list_length (req_list_length),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_is_allocated(rsp_is_allocated),
      .rsp_free_blocks (rsp_free_blocks),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // register value as the block applies it: 1..BLOCKS_MAX
   function automatic int clamp_blocks(input int v);
      if (v < 1) return 1;
      if (v > BLOCKS_MAX) return BLOCKS_MAX;
      return v;
   endfunction

   // next allocator reply for one accepted word, updating the shadow state
   task automatic allocator_predict(input logic [CMD_W-1:0] cmd,
                                    input logic [BLOCK_W-1:0] blk,
                                    input logic [LEN_IN_W-1:0] len,
                                    output bit has_reply, output reply_type rep);
      status_type st;
      int i, j;
      has_reply = 1'b1;
      st = STATUS_OK;
      rep.is_allocated = 1'b0;
      case (cmd)
         CMD_START: begin
            collecting = 1'b0;
            entries_left = 0;
            list_fill = 0;
            if (shadow_free == 0) st = STATUS_FULL;
            else if (int'(blk) >= shadow_limit || int'(len) > LIST_MAX) st = STATUS_RANGE;
            else if (shadow_map[blk]) st = STATUS_INDEX_TAKEN;
            else if (int'(shadow_free) < int'(len) + 1) st = STATUS_NOT_ENOUGH;
            else begin
               pending_index = blk;
               if (len == 0) begin
                  shadow_map[blk] = 1'b1;
                  shadow_free = shadow_free - 11'd1;
               end else begin
                  entries_left = int'(len);
                  collecting = 1'b1;
                  has_reply = 1'b0;
               end
            end
         end
         CMD_ENTRY: begin
            if (!collecting || list_fill >= LIST_MAX) st = STATUS_RANGE;
            else begin
               entry_buf[list_fill] = blk;
               list_fill++;
               entries_left--;
               if (entries_left != 0) has_reply = 1'b0;
               else begin
                  collecting = 1'b0;
                  // whole-list check: self index, then range, then taken or repeated
                  for (i = 0; i < list_fill; i++)
                     if (st == STATUS_OK && entry_buf[i] == pending_index)
                        st = STATUS_SELF_INDEX;
                  for (i = 0; i < list_fill; i++)
                     if (st == STATUS_OK && int'(entry_buf[i]) >= shadow_limit)
                        st = STATUS_RANGE;
                  for (i = 0; i < list_fill; i++) begin
                     if (st == STATUS_OK && shadow_map[entry_buf[i]]) st = STATUS_TAKEN;
                     for (j = 0; j < i; j++)
                        if (st == STATUS_OK && entry_buf[j] == entry_buf[i])
                           st = STATUS_TAKEN;
                  end
                  if (st == STATUS_OK) begin
                     shadow_map[pending_index] = 1'b1;
                     for (i = 0; i < list_fill; i++) shadow_map[entry_buf[i]] = 1'b1;
                     shadow_free = shadow_free - 11'(list_fill + 1);
                  end
                  list_fill = 0;
               end
            end
         end
         CMD_QUERY: begin
            if (int'(blk) >= shadow_limit) st = STATUS_RANGE;
            else rep.is_allocated = shadow_map[blk];
         end
         default: has_reply = 1'b0;
      endcase
      rep.status = st;
      rep.free_blocks = shadow_free;
   endtask

   // driver: one word per start, held until the block takes it
   always @(negedge clock) begin
      req_word_type w;
      if (reset) begin
         start <= 1'b0;
      end else if (start && words_accepted != words_sent) begin
         // still waiting on busy
      end else begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (drain_hold) begin
            if (expected_replies.size() == 0) drain_hold = 1'b0;
            start <= 1'b0;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            if (w.drain) begin
               drain_hold = 1'b1;
               start <= 1'b0;
            end else begin
               req_command      <= w.cmd;
               req_block_number <= w.blk;
               req_list_length  <= w.len;
               start            <= 1'b1;
               words_sent++;
               gap_left = w.gap;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check replies first, then predict the word taken at this edge
   always @(posedge clock) begin
      reply_type want, pred;
      bit        has_reply;
      int        v;
      if (!reset) begin
         if (rsp_valid) begin
            replies_checked++;
            if (expected_replies.size() == 0) begin
               $display("%0t: reply with none expected, status %0d free %0d",
                        $time, rsp_status, rsp_free_blocks);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_is_allocated !== want.is_allocated) begin
                  $display("%0t: is_allocated expected %0d, got %0d",
                           $time, want.is_allocated, rsp_is_allocated);
                  mismatch_count++;
               end
               if (rsp_free_blocks !== want.free_blocks) begin
                  $display("%0t: free_blocks expected %0d, got %0d",
                           $time, want.free_blocks, rsp_free_blocks);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            allocator_predict(req_command, req_block_number, req_list_length, has_reply, pred);
            if (has_reply) expected_replies.push_back(pred);
            words_accepted++;
         end
         if (csr_valid && csr_ready) begin
            // block count write: clear map, reload count, drop any list
            v = clamp_blocks(int'(csr_wdata));
            shadow_limit = v;
            foreach (shadow_map[i]) shadow_map[i] = 1'b0;
            shadow_free = 11'(v);
            pending_index = '0;
            entries_left = 0;
            list_fill = 0;
            collecting = 1'b0;
            csr_writes++;
         end
      end
   end

   // watchdog on cycles with no traffic on any channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog expired, %0d replies outstanding",
                  $time, expected_replies.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // queue one request word with a random trailing gap
   task automatic push_word(input logic [CMD_W-1:0] cmd, input int blk, input int len);
      req_word_type w;
      int r;
      w.cmd = cmd;
      w.blk = BLOCK_W'(blk);
      w.len = LEN_IN_W'(len);
      w.drain = 1'b0;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) w.gap = 0;
      else if (r < 92) w.gap = $urandom_range(1, 3);
      else w.gap = $urandom_range(8, 40);
      pending_words.push_back(w);
   endtask

   // sender holds off here until every reply has come back
   task automatic push_drain();
      req_word_type w;
      w.cmd = CMD_NONE;
      w.blk = '0;
      w.len = '0;
      w.gap = 0;
      w.drain = 1'b1;
      pending_words.push_back(w);
   endtask

   // wait for the block to go quiet, including words that give no reply
   task automatic settle();
      while (pending_words.size() != 0 || start || drain_hold || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_blocks(input int value);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= CFG_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random traffic: mostly well-formed lists, some broken ones and noise
   task automatic gen_random(input int count, input int nblk, input bit long_first);
      int made, r, idx, len, base, stride, fault, k, spot, blk, drain_at;
      made = 0;
      drain_at = count / 2 + $urandom_range(0, count / 4);
      no_idle = 1'b0;
      while (made < count) begin
         if (made >= drain_at) begin
            push_drain();
            drain_at = count * 10;
         end
         if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            idx = $urandom_range(0, nblk - 1);
            if (long_first) begin
               len = LIST_MAX;
               long_first = 1'b0;
            end else if ($urandom_range(0, 9) == 0) len = $urandom_range(9, LIST_MAX);
            else len = $urandom_range(0, 8);
            fault = $urandom_range(0, 11);
            spot = (len > 0) ? $urandom_range(0, len - 1) : 0;
            base = $urandom_range(0, nblk - 1);
            stride = $urandom_range(1, 3);
            push_word(CMD_START, idx, len);
            for (k = 0; k < len; k++) begin
               if (fault == FAULT_SHORT && k == spot) break;
               blk = (base + k * stride) % nblk;
               if (k == spot) begin
                  case (fault)
                     FAULT_SELF:   blk = idx;
                     FAULT_REPEAT: if (k > 0) blk = (base + (k - 1) * stride) % nblk;
                     FAULT_RANGE:
                        if (nblk < BLOCKS_MAX) blk = $urandom_range(nblk, BLOCKS_MAX - 1);
                     FAULT_QUERY:
                        push_word(CMD_QUERY, $urandom_range(0, BLOCKS_MAX - 1), 0);
                     default: ;
                  endcase
               end
               push_word(CMD_ENTRY, blk, $urandom_range(0, 127));
            end
            made += len + 1;
         end else if (r < 85) begin
            if ($urandom_range(0, 4) == 0) blk = $urandom_range(0, BLOCKS_MAX - 1);
            else blk = $urandom_range(0, nblk - 1);
            push_word(CMD_QUERY, blk, $urandom_range(0, 127));
            made++;
         end else if (r < 92) begin
            push_word(CMD_ENTRY, $urandom_range(0, BLOCKS_MAX - 1), $urandom_range(0, 127));
            made++;
         end else if (r < 96) begin
            // dropped word, not counted
            push_word(CMD_NONE, $urandom_range(0, BLOCKS_MAX - 1), $urandom_range(0, 127));
         end else begin
            push_word(CMD_START, $urandom_range(0, BLOCKS_MAX - 1), $urandom_range(0, 127));
            made++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int v;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset block count
      push_word(CMD_QUERY, 0, 0);
      push_word(CMD_QUERY, 1023, 127);
      push_word(CMD_ENTRY, 17, 0);                    // entry while idle
      push_word(CMD_NONE, 1023, 127);
      push_word(CMD_START, 1023, 0);                  // zero-length list commits at once
      push_word(CMD_QUERY, 1023, 0);
      push_word(CMD_START, 1023, 0);                  // index already taken
      push_word(CMD_START, 5, 65);                    // list too long
      push_word(CMD_START, 5, 127);
      push_word(CMD_START, 5, 2);                     // entry equals index
      push_word(CMD_ENTRY, 6, 0);
      push_word(CMD_ENTRY, 5, 0);
      push_word(CMD_START, 10, 2);                    // entry already allocated
      push_word(CMD_ENTRY, 11, 0);
      push_word(CMD_ENTRY, 1023, 0);
      push_word(CMD_START, 10, 2);                    // repeated entry
      push_word(CMD_ENTRY, 12, 0);
      push_word(CMD_ENTRY, 12, 0);
      push_word(CMD_START, 20, 2);                    // restart abandons this list
      push_word(CMD_ENTRY, 21, 0);
      push_word(CMD_START, 40, 1);                    // query while collecting
      push_word(CMD_QUERY, 40, 0);
      push_word(CMD_ENTRY, 41, 0);
      push_word(CMD_QUERY, 41, 0);

      // one block only; zero clamps to one
      write_blocks(0);
      push_word(CMD_START, 0, 1);                     // not enough free
      push_word(CMD_START, 0, 0);
      push_word(CMD_START, 0, 0);                     // map full
      push_word(CMD_QUERY, 1, 0);                     // query out of range

      // three blocks: range and check order
      write_blocks(3);
      push_word(CMD_START, 5, 0);                     // index out of range
      push_word(CMD_START, 0, 2);                     // entry out of range
      push_word(CMD_ENTRY, 1, 0);
      push_word(CMD_ENTRY, 700, 0);
      push_word(CMD_START, 0, 2);                     // self index wins over range
      push_word(CMD_ENTRY, 700, 0);
      push_word(CMD_ENTRY, 0, 0);
      push_word(CMD_START, 1, 2);                     // fills the map
      push_word(CMD_ENTRY, 0, 0);
      push_word(CMD_ENTRY, 2, 0);

      // random phases over several block counts
      write_blocks(2047);
      gen_random(220, clamp_blocks(2047), 1'b1);
      write_blocks(BLOCKS_MAX);
      gen_random(200, BLOCKS_MAX, 1'b0);
      v = $urandom_range(2, 64);
      write_blocks(v);
      gen_random(120, v, 1'b0);
      write_blocks(BLOCKS_MAX + 1);
      gen_random(200, clamp_blocks(BLOCKS_MAX + 1), 1'b0);
      v = $urandom_range(65, BLOCKS_MAX - 1);
      write_blocks(v);
      gen_random(200, v, 1'b0);
      write_blocks(1);
      gen_random(30, 1, 1'b0);

      settle();
      $display("Ran %0d request words and %0d replies over %0d block count writes,",
               words_accepted, replies_checked, csr_writes);
      $display("from one block up to the full map, with list lengths 0 to %0d.", LIST_MAX);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
